>>> design/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI package
// Widths, register codes, sequencer states and divider control types shared
// by the relative strength index core and its divider.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int PRICE_WIDTH  = 32;
    localparam int AVG_WIDTH    = 56;
    localparam int PERIOD_WIDTH = 8;
    localparam int LEVEL_WIDTH  = 23;
    localparam int CNT_WIDTH    = 9;
    localparam int SIG_WIDTH    = 2;

    localparam int NUM_WIDTH    = 64;
    localparam int DEN_WIDTH    = AVG_WIDTH + 2;
    localparam int STEP_WIDTH   = 7;
    localparam int G25_WIDTH    = AVG_WIDTH + 5;

    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;

    localparam logic [LEVEL_WIDTH-1:0]  RSI_FULL         = 23'd6553600;
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET     = 8'd14;
    localparam logic [LEVEL_WIDTH-1:0]  OVERSOLD_RESET   = 23'd1966080;
    localparam logic [LEVEL_WIDTH-1:0]  OVERBOUGHT_RESET = 23'd4587520;

    localparam logic [STEP_WIDTH-1:0] DIV_AVG_STEPS = 7'd64;
    localparam logic [STEP_WIDTH-1:0] DIV_RSI_STEPS = 7'd23;

    localparam logic [1:0] REG_PERIOD     = 2'd0;
    localparam logic [1:0] REG_OVERSOLD   = 2'd1;
    localparam logic [1:0] REG_OVERBOUGHT = 2'd2;

    localparam logic [SIG_WIDTH-1:0] SIG_HOLD = 2'd0;
    localparam logic [SIG_WIDTH-1:0] SIG_BUY  = 2'd1;
    localparam logic [SIG_WIDTH-1:0] SIG_SELL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_GLOAD,
        S_GWAIT,
        S_LLOAD,
        S_LWAIT,
        S_CHK,
        S_RMUL,
        S_RLOAD,
        S_RWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [STEP_WIDTH-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> design/rsi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI input channel
// Valid/ready channel carrying one price and the new-series flag.
// ----------------------------------------------------------------------------
interface rsi_in_if;
    import rsi_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PRICE_WIDTH-1:0] price;
    logic                   new_series;

    modport source (output valid, output price, output new_series, input ready);
    modport sink (input valid, input price, input new_series, output ready);

endinterface

>>> design/rsi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI output channel
// Valid/ready channel carrying the readiness flag, the RSI value and the
// trading signal.
// ----------------------------------------------------------------------------
interface rsi_out_if;
    import rsi_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ready_res;
    logic [LEVEL_WIDTH-1:0] rsi;
    logic [SIG_WIDTH-1:0]   signal;

    modport source (output valid, output ready_res, output rsi, output signal, input ready);
    modport sink (input valid, input ready_res, input rsi, input signal, output ready);

endinterface

>>> design/rsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI shared divider
// Restoring divider, one quotient bit per cycle, with a preloadable partial
// remainder and a programmable number of steps.
// ----------------------------------------------------------------------------
module rsi_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rsi_pkg::t_div_ctl                i_ctl,
    input  logic [rsi_pkg::DEN_WIDTH-1:0]    i_rem,
    input  logic [rsi_pkg::NUM_WIDTH-1:0]    i_num,
    input  logic [rsi_pkg::DEN_WIDTH-1:0]    i_den,
    output rsi_pkg::t_div_sts                o_sts,
    output logic [rsi_pkg::NUM_WIDTH-1:0]    o_quo
);
    import rsi_pkg::*;

    logic [DEN_WIDTH-1:0]  r_rem;
    logic [DEN_WIDTH-1:0]  r_den;
    logic [NUM_WIDTH-1:0]  r_q;
    logic [STEP_WIDTH-1:0] r_cnt;
    logic                  r_done;

    logic [DEN_WIDTH:0]    w_rr;
    logic [DEN_WIDTH:0]    w_diff;
    logic                  w_ge;

    assign w_rr   = {r_rem, r_q[NUM_WIDTH-1]};
    assign w_ge   = (w_rr >= {1'b0, r_den});
    assign w_diff = w_rr - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_cnt <= i_ctl.steps;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == STEP_WIDTH'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DEN_WIDTH-1:0] : w_rr[DEN_WIDTH-1:0];
            r_q   <= {r_q[NUM_WIDTH-2:0], w_ge};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_quo      = r_q;

endmodule

>>> design/rsi_wilder_smoothing_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI Wilder smoothing core
// Relative strength index over a price stream with Wilder smoothing.
//
// Each transaction on i_in carries one price (16 fractional bits) and a flag
// that starts a new series; each gives exactly one transaction on o_out with
// the readiness flag, the RSI (0 to 100, 16 fractional bits) and a hold, buy
// or sell signal. Period and thresholds are to be set over the APB port only
// while idle; the core itself does not enforce this. One transaction is
// processed at a time and i_in.ready is low meanwhile. A transaction that
// starts a series, or adds to the first sums without completing them, skips
// the divider. Once the sums are complete, the two 64-step divisions of the
// gain and loss averages and the 23-step RSI division share one restoring
// divider; the RSI division is skipped when the loss average is zero.
// The result sits in an output register: the next price is taken while it
// waits, and a stalled receiver holds the core only when a second result is
// ready. Reset restores the default period of 14 and thresholds of 30 and 70
// and clears the series state.
// ----------------------------------------------------------------------------
module rsi_wilder_smoothing_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rsi_in_if.sink                          i_in,
    rsi_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rsi_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [rsi_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [rsi_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);
    import rsi_pkg::*;

    logic [PERIOD_WIDTH-1:0] r_period;
    logic [LEVEL_WIDTH-1:0]  r_oversold;
    logic [LEVEL_WIDTH-1:0]  r_overbought;

    t_state                  r_state;
    t_state                  n_state;

    logic [PRICE_WIDTH-1:0]  r_last_price;
    logic                    r_have;
    logic                    r_restart;
    logic [PRICE_WIDTH-1:0]  r_gain_in;
    logic [PRICE_WIDTH-1:0]  r_loss_in;
    logic [CNT_WIDTH-1:0]    r_count;
    logic [AVG_WIDTH-1:0]    r_gain_avg;
    logic [AVG_WIDTH-1:0]    r_loss_avg;
    logic                    r_smooth;
    logic                    r_ready;
    logic [LEVEL_WIDTH-1:0]  r_rsi;
    logic [G25_WIDTH-1:0]    r_g25;
    logic [DEN_WIDTH-1:0]    r_sum;

    logic                    r_out_valid;
    logic                    r_out_ready_res;
    logic [LEVEL_WIDTH-1:0]  r_out_rsi;
    logic [SIG_WIDTH-1:0]    r_out_signal;

    logic                    w_cfg_wr;
    logic                    w_accept;
    logic                    w_out_load;
    logic [PERIOD_WIDTH-1:0] w_p;
    logic [PERIOD_WIDTH-1:0] w_pm1;
    logic                    w_cnt_lt;
    logic                    w_cnt_last;
    logic [CNT_WIDTH-1:0]    w_cnt_next;
    logic [AVG_WIDTH-1:0]    w_mul_avg;
    logic [PRICE_WIDTH-1:0]  w_mul_x;
    logic [NUM_WIDTH-1:0]    w_prod;
    logic [G25_WIDTH-1:0]    w_g_ext;
    logic [SIG_WIDTH-1:0]    w_signal;

    t_div_ctl                w_div_ctl;
    t_div_sts                w_div_sts;
    logic [DEN_WIDTH-1:0]    w_div_rem;
    logic [NUM_WIDTH-1:0]    w_div_num;
    logic [DEN_WIDTH-1:0]    w_div_den;
    logic [NUM_WIDTH-1:0]    w_div_quo;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= PERIOD_RESET;
            r_oversold   <= OVERSOLD_RESET;
            r_overbought <= OVERBOUGHT_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_PERIOD:     r_period     <= pwdata[PERIOD_WIDTH-1:0];
                REG_OVERSOLD:   r_oversold   <= pwdata[LEVEL_WIDTH-1:0];
                REG_OVERBOUGHT: r_overbought <= pwdata[LEVEL_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PERIOD:     prdata = DATA_WIDTH'(r_period);
            REG_OVERSOLD:   prdata = DATA_WIDTH'(r_oversold);
            REG_OVERBOUGHT: prdata = DATA_WIDTH'(r_overbought);
            default:        prdata = '0;
        endcase
    end

    // Datapath helpers.
    assign w_p        = (r_period == '0) ? PERIOD_WIDTH'(1) : r_period;
    assign w_pm1      = w_p - 1'b1;
    assign w_cnt_lt   = (r_count < CNT_WIDTH'(w_p));
    assign w_cnt_next = r_count + 1'b1;
    assign w_cnt_last = (w_cnt_next == CNT_WIDTH'(w_p));
    assign w_mul_avg  = (r_state == S_LLOAD) ? r_loss_avg : r_gain_avg;
    assign w_mul_x    = (r_state == S_LLOAD) ? r_loss_in : r_gain_in;
    assign w_prod     = NUM_WIDTH'(w_mul_avg) * NUM_WIDTH'(w_pm1) + NUM_WIDTH'(w_mul_x);
    assign w_g_ext    = G25_WIDTH'(r_gain_avg);

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        if (r_ready && (r_rsi <= r_oversold)) begin
            w_signal = SIG_BUY;
        end else if (r_ready && (r_rsi >= r_overbought)) begin
            w_signal = SIG_SELL;
        end else begin
            w_signal = SIG_HOLD;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_UPD;
            end
            S_UPD: begin
                if (r_restart) begin
                    n_state = S_CHK;
                end else if (w_cnt_lt) begin
                    n_state = w_cnt_last ? S_GLOAD : S_CHK;
                end else begin
                    n_state = S_GLOAD;
                end
            end
            S_GLOAD: n_state = S_GWAIT;
            S_GWAIT: begin
                if (w_div_sts.done) n_state = S_LLOAD;
            end
            S_LLOAD: n_state = S_LWAIT;
            S_LWAIT: begin
                if (w_div_sts.done) n_state = S_CHK;
            end
            S_CHK: begin
                if (w_cnt_lt || (r_loss_avg == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RMUL;
                end
            end
            S_RMUL:  n_state = S_RLOAD;
            S_RLOAD: n_state = S_RWAIT;
            S_RWAIT: begin
                if (w_div_sts.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_in.ready      = 1'b0;
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = DIV_AVG_STEPS;
        w_div_rem       = '0;
        w_div_num       = w_prod;
        w_div_den       = DEN_WIDTH'(w_p);
        case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_GLOAD, S_LLOAD: begin
                w_div_ctl.start = 1'b1;
                if (!r_smooth) w_div_num = NUM_WIDTH'(w_mul_avg);
            end
            S_RLOAD: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = DIV_RSI_STEPS;
                w_div_rem       = DEN_WIDTH'(r_g25[G25_WIDTH-1:5]);
                w_div_num       = {r_g25[4:0], {(NUM_WIDTH-5){1'b0}}};
                w_div_den       = r_sum;
            end
            default: begin
            end
        endcase
    end

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_rem   (w_div_rem),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_sts   (w_div_sts),
        .o_quo   (w_div_quo)
    );

    // Control and series state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have       <= 1'b0;
            r_restart    <= 1'b0;
            r_count      <= '0;
            r_gain_avg   <= '0;
            r_loss_avg   <= '0;
            r_last_price <= '0;
            r_smooth     <= 1'b0;
            r_ready      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_restart    <= i_in.new_series || !r_have;
                r_have       <= 1'b1;
                r_last_price <= i_in.price;
            end
            case (r_state)
                S_UPD: begin
                    if (r_restart) begin
                        r_count    <= '0;
                        r_gain_avg <= '0;
                        r_loss_avg <= '0;
                    end else if (w_cnt_lt) begin
                        r_gain_avg <= r_gain_avg + AVG_WIDTH'(r_gain_in);
                        r_loss_avg <= r_loss_avg + AVG_WIDTH'(r_loss_in);
                        r_count    <= w_cnt_next;
                        r_smooth   <= 1'b0;
                    end else begin
                        r_smooth   <= 1'b1;
                    end
                end
                S_GWAIT: begin
                    if (w_div_sts.done) r_gain_avg <= w_div_quo[AVG_WIDTH-1:0];
                end
                S_LWAIT: begin
                    if (w_div_sts.done) r_loss_avg <= w_div_quo[AVG_WIDTH-1:0];
                end
                S_CHK: r_ready <= !w_cnt_lt;
                default: begin
                end
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gain_in <= (i_in.price > r_last_price) ? i_in.price - r_last_price : '0;
            r_loss_in <= (i_in.price < r_last_price) ? r_last_price - i_in.price : '0;
        end
        case (r_state)
            S_CHK: begin
                if (w_cnt_lt) begin
                    r_rsi <= '0;
                end else begin
                    r_rsi <= RSI_FULL;
                end
            end
            S_RMUL: begin
                r_g25 <= (w_g_ext << 4) + (w_g_ext << 3) + w_g_ext;
                r_sum <= DEN_WIDTH'(r_gain_avg) + DEN_WIDTH'(r_loss_avg);
            end
            S_RWAIT: begin
                if (w_div_sts.done) r_rsi <= w_div_quo[LEVEL_WIDTH-1:0];
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_ready_res <= r_ready;
            r_out_rsi       <= r_rsi;
            r_out_signal    <= w_signal;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.ready_res = r_out_ready_res;
    assign o_out.rsi       = r_out_rsi;
    assign o_out.signal    = r_out_signal;

`ifndef SYNTH
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctl.start |-> !w_div_sts.busy)
        else $error("Divider started while busy.");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("Output became valid outside the output state.");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_out.rsi <= RSI_FULL)
        else $error("RSI above full scale.");

    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready_res |-> o_out.rsi == '0 && o_out.signal == SIG_HOLD)
        else $error("Nonzero RSI or signal before the series is ready.");
`endif

endmodule

>>> dv/rsi_wilder_smoothing_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSI Wilder smoothing core testbench
// Drives price transactions into the core under random idling and back
// pressure, and checks every result against the directed table or an in-bench
// predictor of the gain/loss averaging, the RSI ratio and the hold/buy/sell
// signal. Covers a directed table first, then random price walks under
// several period and threshold settings programmed over the APB port.
// ----------------------------------------------------------------------------
module rsi_wilder_smoothing_core_tb;
    import rsi_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_AT       = 920;
    localparam int HOLD_CYCLES   = 1000;
    localparam int NUM_SEGMENTS  = 6;
    localparam int NUM_DIRECTED  = 24;
    localparam int PERIOD_ZERO_ROW = 16;

    typedef struct packed {
        logic                   ready_res;
        logic [LEVEL_WIDTH-1:0] rsi;
        logic [SIG_WIDTH-1:0]   signal;
    } t_rsi_result;

    typedef struct packed {
        logic [PRICE_WIDTH-1:0] price;
        logic                   new_series;
        logic                   typed;
        t_rsi_result            result;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0000_0000, 1'b1, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0001_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0002_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0003_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0004_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0005_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0006_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0007_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0008_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0009_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h000A_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h000B_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h000C_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h000D_0000, 1'b0, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h000E_0000, 1'b0, 1'b1, '{1'b1, RSI_FULL, SIG_SELL}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h0000_0000, 1'b0, 1'b1, '{1'b1, 23'd0, SIG_BUY}},
        '{32'h0000_0000, 1'b0, 1'b1, '{1'b1, RSI_FULL, SIG_SELL}},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b1, RSI_FULL, SIG_SELL}},
        '{32'h8000_0000, 1'b0, 1'b1, '{1'b1, 23'd0, SIG_BUY}},
        '{32'h1234_5678, 1'b1, 1'b1, '{1'b0, 23'd0, SIG_HOLD}},
        '{32'h1234_5679, 1'b0, 1'b1, '{1'b1, RSI_FULL, SIG_SELL}},
        '{32'hEDCB_A987, 1'b0, 1'b0, '{1'b0, 23'd0, SIG_HOLD}}
    };

    localparam int SEG_PERIOD     [NUM_SEGMENTS] = '{5, 255, 1, 2, 14, 0};
    localparam int SEG_OVERSOLD   [NUM_SEGMENTS] = '{1966080, 0, 6553600, 3276800, 3276800, 0};
    localparam int SEG_OVERBOUGHT [NUM_SEGMENTS] = '{4587520, 6553600, 0, 3276800, 3276800, 0};
    localparam int SEG_ITEMS      [NUM_SEGMENTS] = '{150, 400, 150, 150, 150, 150};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    rsi_in_if  in_if ();
    rsi_out_if out_if ();

    rsi_wilder_smoothing_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [PERIOD_WIDTH-1:0] cfg_period;
    logic [LEVEL_WIDTH-1:0]  cfg_oversold;
    logic [LEVEL_WIDTH-1:0]  cfg_overbought;

    logic [PRICE_WIDTH-1:0]  pr_last_price;
    logic [CNT_WIDTH-1:0]    pr_change_count;
    logic [AVG_WIDTH-1:0]    pr_gain_avg;
    logic [AVG_WIDTH-1:0]    pr_loss_avg;
    logic                    pr_have_price;

    t_rsi_result             rsi_expected_q [$];
    t_rsi_result             oldest_result;
    logic [PRICE_WIDTH-1:0]  walk_price;

    int src_idle_pct;
    int snk_idle_pct;
    int accepted_count;
    int cycle_count;
    int hold_left;
    bit hold_done;
    int mismatch_count;
    int reg_mismatch_count;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_rsi_result predict_rsi(input logic [PRICE_WIDTH-1:0] price,
                                                input logic new_series);
        logic [CNT_WIDTH-1:0] p;
        logic [63:0]          gain;
        logic [63:0]          loss;
        logic [63:0]          gain_num;
        logic [63:0]          loss_num;
        logic [63:0]          total;
        logic [127:0]         quotient;
        t_rsi_result          res;

        p = (cfg_period == '0) ? CNT_WIDTH'(1) : CNT_WIDTH'(cfg_period);
        if (new_series || !pr_have_price) begin
            pr_change_count = '0;
            pr_gain_avg     = '0;
            pr_loss_avg     = '0;
            pr_have_price   = 1'b1;
        end else begin
            gain = (price > pr_last_price) ? 64'(price - pr_last_price) : 64'd0;
            loss = (price < pr_last_price) ? 64'(pr_last_price - price) : 64'd0;
            if (pr_change_count < p) begin
                pr_gain_avg     = pr_gain_avg + AVG_WIDTH'(gain);
                pr_loss_avg     = pr_loss_avg + AVG_WIDTH'(loss);
                pr_change_count = pr_change_count + 1'b1;
                if (pr_change_count == p) begin
                    pr_gain_avg = pr_gain_avg / AVG_WIDTH'(p);
                    pr_loss_avg = pr_loss_avg / AVG_WIDTH'(p);
                end
            end else begin
                gain_num    = 64'(pr_gain_avg) * 64'(p - 9'd1) + gain;
                loss_num    = 64'(pr_loss_avg) * 64'(p - 9'd1) + loss;
                pr_gain_avg = AVG_WIDTH'(gain_num / 64'(p));
                pr_loss_avg = AVG_WIDTH'(loss_num / 64'(p));
            end
        end
        pr_last_price = price;

        res = '0;
        if (pr_change_count >= p) begin
            res.ready_res = 1'b1;
            if (pr_loss_avg == '0) begin
                res.rsi = RSI_FULL;
            end else begin
                total    = 64'(pr_gain_avg) + 64'(pr_loss_avg);
                quotient = (128'(pr_gain_avg) * 128'(RSI_FULL)) / 128'(total);
                res.rsi  = quotient[LEVEL_WIDTH-1:0];
            end
            if (res.rsi <= cfg_oversold) begin
                res.signal = SIG_BUY;
            end else if (res.rsi >= cfg_overbought) begin
                res.signal = SIG_SELL;
            end
        end
        return res;
    endfunction

    function automatic logic [PRICE_WIDTH-1:0] next_walk_price();
        int                     roll;
        logic [PRICE_WIDTH-1:0] delta;

        roll = $urandom_range(99);
        if (roll < 8) begin
            walk_price = $urandom();
        end else if (roll < 11) begin
            walk_price = $urandom_range(1) ? '1 : '0;
        end else if (roll >= 18) begin
            delta = $urandom() >> $urandom_range(31, 8);
            if ($urandom_range(1)) begin
                walk_price = (walk_price > ~delta) ? '1 : walk_price + delta;
            end else begin
                walk_price = (walk_price < delta) ? '0 : walk_price - delta;
            end
        end
        return walk_price;
    endfunction

    task automatic send_price(input logic [PRICE_WIDTH-1:0] price, input logic new_series,
                              input logic typed, input t_rsi_result typed_result);
        t_rsi_result predicted;

        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.price      <= price;
        in_if.new_series <= new_series;
        do @(posedge i_clk); while (!in_if.ready);
        accepted_count++;
        predicted = predict_rsi(price, new_series);
        rsi_expected_q = {rsi_expected_q, typed ? typed_result : predicted};
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (rsi_expected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] index, input logic [DATA_WIDTH-1:0] value);
        logic [DATA_WIDTH-1:0] mask;

        mask    = (index == REG_PERIOD) ? DATA_WIDTH'(8'hFF) : DATA_WIDTH'(23'h7FFFFF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            $error("register %0d read back: expected %0d, actual %0d",
                   index, value & mask, prdata & mask);
            reg_mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_PERIOD:     cfg_period     = value[PERIOD_WIDTH-1:0];
            REG_OVERSOLD:   cfg_oversold   = value[LEVEL_WIDTH-1:0];
            REG_OVERBOUGHT: cfg_overbought = value[LEVEL_WIDTH-1:0];
            default:        ;
        endcase
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (rsi_expected_q.size() == 0) begin
                $error("result transaction with none expected: ready_res %0d, rsi %0d, signal %0d",
                       out_if.ready_res, out_if.rsi, out_if.signal);
                mismatch_count++;
            end else begin
                oldest_result = rsi_expected_q.pop_front();
                if (out_if.ready_res !== oldest_result.ready_res) begin
                    $error("ready_res mismatch: expected %0d, actual %0d",
                           oldest_result.ready_res, out_if.ready_res);
                    mismatch_count++;
                end
                if (out_if.rsi !== oldest_result.rsi) begin
                    $error("rsi mismatch: expected %0d, actual %0d",
                           oldest_result.rsi, out_if.rsi);
                    mismatch_count++;
                end
                if (out_if.signal !== oldest_result.signal) begin
                    $error("signal mismatch: expected %0d, actual %0d",
                           oldest_result.signal, out_if.signal);
                    mismatch_count++;
                end
            end
        end
    end

    // The receiver stalls at random, and once holds off for a long stretch so
    // that the core fills its output register and stalls its input.
    initial begin
        out_if.ready = 1'b0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && accepted_count >= HOLD_AT) begin
                out_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        int                     seg_period;
        logic [PRICE_WIDTH-1:0] price;
        logic                   new_series;

        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.price        = '0;
        in_if.new_series   = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cfg_period         = PERIOD_RESET;
        cfg_oversold       = OVERSOLD_RESET;
        cfg_overbought     = OVERBOUGHT_RESET;
        pr_last_price      = '0;
        pr_change_count    = '0;
        pr_gain_avg        = '0;
        pr_loss_avg        = '0;
        pr_have_price      = 1'b0;
        walk_price         = 32'h0064_0000;
        src_idle_pct       = 35;
        snk_idle_pct       = 56;
        accepted_count     = 0;
        cycle_count        = 0;
        mismatch_count     = 0;
        reg_mismatch_count = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int row = 0; row < NUM_DIRECTED; row++) begin
            if (row == PERIOD_ZERO_ROW) begin
                wait_drained();
                write_config(REG_PERIOD, '0);
            end
            send_price(DIRECTED_ROWS[row].price, DIRECTED_ROWS[row].new_series,
                       DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].result);
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    src_idle_pct = 35;
                    snk_idle_pct = 56;
                end
                1: begin
                    src_idle_pct = 56;
                    snk_idle_pct = 35;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            wait_drained();
            if (seg == NUM_SEGMENTS - 1) begin
                seg_period = $urandom_range(40, 1);
                write_config(REG_PERIOD, DATA_WIDTH'(seg_period));
                write_config(REG_OVERSOLD, DATA_WIDTH'($urandom_range(6553600, 0)));
                write_config(REG_OVERBOUGHT, DATA_WIDTH'($urandom_range(6553600, 0)));
            end else begin
                seg_period = SEG_PERIOD[seg];
                write_config(REG_PERIOD, DATA_WIDTH'(SEG_PERIOD[seg]));
                write_config(REG_OVERSOLD, DATA_WIDTH'(SEG_OVERSOLD[seg]));
                write_config(REG_OVERBOUGHT, DATA_WIDTH'(SEG_OVERBOUGHT[seg]));
            end
            for (int n = 0; n < SEG_ITEMS[seg]; n++) begin
                price      = next_walk_price();
                new_series = ($urandom_range(4 * seg_period + 20) == 0);
                send_price(price, new_series, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && reg_mismatch_count == 0 && rsi_expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
